// ----- rtl/core/pmdq_pkg.sv -----
// shared constants, types and helpers of the partitioned multi-deque
package pmdq_pkg;

	localparam int SEG_DEPTH  = 16;
	localparam int NUM_QUEUES = 4;
	localparam int DATA_WIDTH = 32;

	localparam int REQ_W = 3;
	localparam int QSEL_W = 2;
	localparam int VAL_W = 32;
	localparam int STAT_W = 2;

	localparam int OW = $clog2(SEG_DEPTH);
	localparam int QW = $clog2(NUM_QUEUES);
	localparam int AW = $clog2(NUM_QUEUES * SEG_DEPTH);

	localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef logic [OW-1:0] off_t;
	typedef logic [QW-1:0] qidx_t;
	typedef logic [AW-1:0] addr_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic occ;
		off_t head;
		off_t tail;
	} ptr_t;

	typedef struct packed {
		status_t status;
		logic signed [VAL_W-1:0] data;
		logic last;
	} res_t;

	function automatic addr_t slot_addr(qidx_t q, off_t off);
		return AW'(q) * AW'(SEG_DEPTH) + AW'(off);
	endfunction

	// low DATA_WIDTH bits of the pushed value, zero above 32 bits
	function automatic word_t to_word(logic [VAL_W-1:0] v);
		word_t w;
		w = '0;
		for (int i = 0; i < DATA_WIDTH; i++) begin
			if (i < VAL_W) w[i] = v[i];
		end
		return w;
	endfunction

	function automatic logic [VAL_W-1:0] to_val(word_t w);
		logic [VAL_W-1:0] v;
		v = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (i < DATA_WIDTH) v[i] = w[i];
		end
		return v;
	endfunction

endpackage

// ----- rtl/core/pmdq_channels.sv -----
// request and result channel interfaces of the partitioned multi-deque
interface pmdq_req_if;
	logic valid;
	logic ready;
	logic [pmdq_pkg::REQ_W-1:0] req_type;
	logic [pmdq_pkg::QSEL_W-1:0] queue_sel;
	logic signed [pmdq_pkg::VAL_W-1:0] item_value;

	modport source (output valid, req_type, queue_sel, item_value, input ready);
	modport sink (input valid, req_type, queue_sel, item_value, output ready);
endinterface

interface pmdq_rsp_if;
	logic valid;
	logic ready;
	logic [pmdq_pkg::STAT_W-1:0] status;
	logic signed [pmdq_pkg::VAL_W-1:0] data_value;
	logic last_flag;

	modport source (output valid, status, data_value, last_flag, input ready);
	modport sink (input valid, status, data_value, last_flag, output ready);
endinterface

// ----- rtl/core/partitioned_multi_deque_top.sv -----
// top level: request sequencer, result register, store and pointer table
//
//  channel   dir  handshake     payload
//  req_ch    in   valid/ready   req_type[2:0] queue_sel[1:0] item_value[31:0]
//  rsp_ch    out  valid/ready   status[1:0] data_value[31:0] last_flag
//
// one request at a time: a request is registered, then executed in S_EXEC; a pop waits in S_POP
// and a dump steps through S_DUMP for the registered read port of the element store.
// reset clears the pointer table and the sequencer; the store is not cleared.
// a result register sits on rsp_ch; a stalled result holds the sequencer, but
// a new request is taken while the last result of the previous one waits.
module partitioned_multi_deque_top (
	input logic      clk,
	input logic      arst_n,
	pmdq_req_if.sink   req_ch,
	pmdq_rsp_if.source rsp_ch
);
	import pmdq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_POP  = 4'b0100,
		S_DUMP = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [REQ_W-1:0] req_q;
	qidx_t q_q;
	logic qok_q;
	word_t item_q;
	off_t idx_q, idx_d;
	off_t last_q, last_d;

	logic rsp_valid_q;
	res_t rsp_q;
	res_t res;
	logic emit;
	logic slot_free;

	ptr_t cur;
	ptr_t nxt;
	logic ptr_we;

	logic st_we, st_re;
	addr_t st_waddr, st_raddr;
	word_t st_rdata;

	pmdq_ptrs u_ptrs (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_sel (q_q),
		.rd_ptr (cur),
		.wr_en  (ptr_we),
		.wr_sel (q_q),
		.wr_ptr (nxt)
	);

	pmdq_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (item_q),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	assign slot_free = !rsp_valid_q || rsp_ch.ready;
	assign req_ch.ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		last_d = last_q;
		res = '{status: STAT_OK, data: '0, last: 1'b1};
		emit = 1'b0;
		nxt = cur;
		ptr_we = 1'b0;
		st_we = 1'b0;
		st_re = 1'b0;
		st_waddr = slot_addr(q_q, '0);
		st_raddr = slot_addr(q_q, cur.head);
		unique case (state_q)
			S_IDLE: begin
				if (req_ch.valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (!qok_q) begin
					state_d = S_IDLE;
				end else begin
					unique case (req_q) inside
						REQ_PUSH_REAR, REQ_PUSH_FRONT: begin
							if (slot_free) begin
								emit = 1'b1;
								state_d = S_IDLE;
								if (!cur.occ) begin
									nxt = '{occ: 1'b1, head: '0, tail: '0};
									ptr_we = 1'b1;
									st_we = 1'b1;
								end else if (req_q == REQ_PUSH_REAR) begin
									if (cur.tail == OW'(SEG_DEPTH - 1)) begin
										res.status = STAT_OVERFLOW;
									end else begin
										nxt.tail = cur.tail + 1'b1;
										ptr_we = 1'b1;
										st_we = 1'b1;
										st_waddr = slot_addr(q_q, nxt.tail);
									end
								end else begin
									if (cur.head == '0) begin
										res.status = STAT_OVERFLOW;
									end else begin
										nxt.head = cur.head - 1'b1;
										ptr_we = 1'b1;
										st_we = 1'b1;
										st_waddr = slot_addr(q_q, nxt.head);
									end
								end
							end
						end
						REQ_POP_FRONT, REQ_POP_REAR: begin
							if (!cur.occ) begin
								if (slot_free) begin
									emit = 1'b1;
									res.status = STAT_UNDERFLOW;
									state_d = S_IDLE;
								end
							end else begin
								// pointer update now, value comes out of the store next cycle
								st_re = 1'b1;
								ptr_we = 1'b1;
								state_d = S_POP;
								if (req_q == REQ_POP_FRONT) begin
									if (cur.head >= cur.tail) nxt = '0;
									else nxt.head = cur.head + 1'b1;
								end else begin
									st_raddr = slot_addr(q_q, cur.tail);
									if (cur.head >= cur.tail || cur.tail == '0) nxt = '0;
									else nxt.tail = cur.tail - 1'b1;
								end
							end
						end
						REQ_DUMP: begin
							if (!cur.occ) begin
								if (slot_free) begin
									emit = 1'b1;
									res.status = STAT_EMPTY;
									state_d = S_IDLE;
								end
							end else begin
								st_re = 1'b1;
								idx_d = cur.head;
								last_d = cur.tail;
								state_d = S_DUMP;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_POP: begin
				if (slot_free) begin
					emit = 1'b1;
					res.data = to_val(st_rdata);
					state_d = S_IDLE;
				end
			end
			S_DUMP: begin
				st_raddr = slot_addr(q_q, idx_q + 1'b1);
				if (slot_free) begin
					emit = 1'b1;
					res.data = to_val(st_rdata);
					res.last = (idx_q == last_q);
					if (idx_q == last_q) begin
						state_d = S_IDLE;
					end else begin
						st_re = 1'b1;
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) rsp_valid_q <= 1'b1;
			else if (rsp_ch.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			req_q <= req_ch.req_type;
			q_q <= QW'(req_ch.queue_sel);
			qok_q <= (32'(req_ch.queue_sel) < NUM_QUEUES);
			item_q <= to_word(req_ch.item_value);
		end
		idx_q <= idx_d;
		last_q <= last_d;
		if (emit) rsp_q <= res;
	end

	assign rsp_ch.valid = rsp_valid_q;
	assign rsp_ch.status = rsp_q.status;
	assign rsp_ch.data_value = rsp_q.data;
	assign rsp_ch.last_flag = rsp_q.last;
endmodule

// ----- rtl/core/pmdq_store.sv -----
// element store: one write port, one registered read port
module pmdq_store (
	input  logic             clk,
	input  logic             we,
	input  pmdq_pkg::addr_t  waddr,
	input  pmdq_pkg::word_t  wdata,
	input  logic             re,
	input  pmdq_pkg::addr_t  raddr,
	output pmdq_pkg::word_t  rdata
);
	import pmdq_pkg::*;

	word_t mem [NUM_QUEUES*SEG_DEPTH];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/core/pmdq_ptrs.sv -----
// per-queue head, tail and occupied state
module pmdq_ptrs (
	input  logic             clk,
	input  logic             arst_n,
	input  pmdq_pkg::qidx_t  rd_sel,
	output pmdq_pkg::ptr_t   rd_ptr,
	input  logic             wr_en,
	input  pmdq_pkg::qidx_t  wr_sel,
	input  pmdq_pkg::ptr_t   wr_ptr
);
	import pmdq_pkg::*;

	ptr_t ptr_q [NUM_QUEUES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) ptr_q[i] <= '0;
		end else if (wr_en) begin
			ptr_q[wr_sel] <= wr_ptr;
		end
	end

	assign rd_ptr = ptr_q[rd_sel];
endmodule

// ----- sim/tb.sv -----
// testbench of the partitioned multi-deque: directed and random requests against a predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pmdq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 360;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX = 10;

	localparam logic [REQ_W-1:0] REQ_BAD_LO = REQ_DUMP + 3'd1;
	localparam logic [REQ_W-1:0] REQ_BAD_HI = '1;

	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} phase_t;

	class deque_scoreboard_t;
		res_t pending_results[$];
		word_t slots[NUM_QUEUES * SEG_DEPTH];
		off_t head[NUM_QUEUES];
		off_t tail[NUM_QUEUES];
		bit occupied[NUM_QUEUES];
		int mismatches;

		function new();
			mismatches = 0;
			foreach (head[q]) begin
				head[q] = '0;
				tail[q] = '0;
				occupied[q] = 1'b0;
			end
			foreach (slots[i]) slots[i] = '0;
		endfunction

		function void add_result(status_t st, word_t d, bit l);
			res_t r;
			r.status = st;
			r.data = d;
			r.last = l;
			pending_results.push_back(r);
		endfunction

		function void note_request(logic [REQ_W-1:0] kind, logic [QSEL_W-1:0] sel,
				logic signed [VAL_W-1:0] value);
			int base;
			word_t w;
			if (kind > REQ_DUMP || int'(sel) >= NUM_QUEUES) return;
			base = int'(sel) * SEG_DEPTH;
			w = word_t'(value);
			case (kind) inside
				REQ_PUSH_REAR, REQ_PUSH_FRONT: begin
					if (!occupied[sel]) begin
						// an empty queue always restarts at the segment start
						head[sel] = '0;
						tail[sel] = '0;
						occupied[sel] = 1'b1;
						slots[base] = w;
						add_result(STAT_OK, '0, 1'b1);
					end else if (kind == REQ_PUSH_REAR) begin
						if (int'(tail[sel]) >= SEG_DEPTH - 1) begin
							add_result(STAT_OVERFLOW, '0, 1'b1);
						end else begin
							tail[sel]++;
							slots[base + int'(tail[sel])] = w;
							add_result(STAT_OK, '0, 1'b1);
						end
					end else if (head[sel] == '0) begin
						add_result(STAT_OVERFLOW, '0, 1'b1);
					end else begin
						head[sel]--;
						slots[base + int'(head[sel])] = w;
						add_result(STAT_OK, '0, 1'b1);
					end
				end
				REQ_POP_FRONT, REQ_POP_REAR: begin
					if (!occupied[sel]) begin
						add_result(STAT_UNDERFLOW, '0, 1'b1);
					end else if (kind == REQ_POP_FRONT) begin
						add_result(STAT_OK, slots[base + int'(head[sel])], 1'b1);
						if (head[sel] >= tail[sel]) begin
							occupied[sel] = 1'b0;
							head[sel] = '0;
							tail[sel] = '0;
						end else begin
							head[sel]++;
						end
					end else begin
						add_result(STAT_OK, slots[base + int'(tail[sel])], 1'b1);
						if (head[sel] >= tail[sel] || tail[sel] == '0) begin
							occupied[sel] = 1'b0;
							head[sel] = '0;
							tail[sel] = '0;
						end else begin
							tail[sel]--;
						end
					end
				end
				default: begin
					if (!occupied[sel]) begin
						add_result(STAT_EMPTY, '0, 1'b1);
					end else begin
						for (int i = int'(head[sel]); i <= int'(tail[sel]); i++)
							add_result(STAT_OK, slots[base + i], i == int'(tail[sel]));
					end
				end
			endcase
		endfunction

		function void check_result(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] d,
				logic l);
			res_t e;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("tb: unexpected result: status %0d data %h last %b", st, d, l);
				return;
			end
			e = pending_results[0];
			pending_results.delete(0);
			if (e.status !== st || e.data !== d || e.last !== l) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display({"tb: mismatch: expected status %0d data %h last %b, ",
						"got status %0d data %h last %b"},
						e.status, e.data, e.last, st, d, l);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int cycles = 0;
	bit src_steady = 1'b0;
	bit snk_steady = 1'b0;
	deque_scoreboard_t sb = new();

	pmdq_req_if req_ch();
	pmdq_rsp_if rsp_ch();

	partitioned_multi_deque_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req_ch),
		.rsp_ch(rsp_ch)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// random idle gap before each item, with occasional stretches of back-to-back items
	function automatic int pick_gap(inout bit steady);
		if ($urandom_range(0, 39) == 0) steady = !steady;
		return steady ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [REQ_W-1:0] pick_kind(phase_t ph, int roll);
		int t[4];
		case (ph)
			PH_FILL: t = '{55, 75, 85, 93};
			PH_DRAIN: t = '{10, 20, 50, 85};
			default: t = '{20, 40, 60, 80};
		endcase
		if (roll < t[0]) return REQ_PUSH_REAR;
		if (roll < t[1]) return REQ_PUSH_FRONT;
		if (roll < t[2]) return REQ_POP_FRONT;
		if (roll < t[3]) return REQ_POP_REAR;
		return REQ_DUMP;
	endfunction

	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [QSEL_W-1:0] sel,
			input logic signed [VAL_W-1:0] value);
		int gap;
		gap = pick_gap(src_steady);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.queue_sel <= sel;
		req_ch.item_value <= value;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(kind, sel, value);
	endtask

	// phases bias one queue toward filling or draining so overflow and front pushes get hit
	task automatic run_random(input int count);
		phase_t phase;
		logic [QSEL_W-1:0] focus;
		logic [QSEL_W-1:0] sel;
		int left;
		phase = PH_FILL;
		focus = '0;
		left = 0;
		for (int n = 0; n < count; n++) begin
			if (left == 0) begin
				phase = phase_t'($urandom_range(0, 2));
				focus = QSEL_W'($urandom_range(0, NUM_QUEUES - 1));
				left = $urandom_range(10, 40);
			end
			left--;
			if ($urandom_range(0, 39) == 0)
				send_request(REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI)),
					QSEL_W'($urandom()), VAL_W'($urandom()));
			sel = ($urandom_range(0, 3) == 0) ?
				QSEL_W'($urandom_range(0, NUM_QUEUES - 1)) : focus;
			send_request(pick_kind(phase, $urandom_range(0, 99)), sel, pick_value());
		end
	endtask

	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = pick_gap(snk_steady);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			sb.check_result(rsp_ch.status, rsp_ch.data_value, rsp_ch.last_flag);
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.queue_sel = '0;
		req_ch.item_value = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queues
		send_request(REQ_DUMP, 2'd0, '0);
		send_request(REQ_POP_FRONT, 2'd1, '1);
		send_request(REQ_POP_REAR, 2'd2, '0);
		// extremes through one queue, front push blocked at the segment start
		send_request(REQ_PUSH_REAR, 2'd0, 32'sh7FFFFFFF);
		send_request(REQ_PUSH_FRONT, 2'd0, 32'sh11111111);
		send_request(REQ_PUSH_REAR, 2'd0, 32'sh80000000);
		send_request(REQ_PUSH_REAR, 2'd0, '1);
		send_request(REQ_PUSH_REAR, 2'd0, '0);
		send_request(REQ_DUMP, 2'd0, '0);
		send_request(REQ_POP_FRONT, 2'd0, '0);
		send_request(REQ_PUSH_FRONT, 2'd0, 32'sh12345678);
		send_request(REQ_POP_REAR, 2'd0, '0);
		send_request(REQ_DUMP, 2'd0, '0);
		// front push into an empty queue, then emptied from the front and the rear
		send_request(REQ_PUSH_FRONT, 2'd3, 32'shA5A5A5A5);
		send_request(REQ_PUSH_REAR, 2'd3, 32'sh5A5A5A5A);
		send_request(REQ_DUMP, 2'd3, '0);
		// unknown request codes give nothing
		send_request(REQ_BAD_LO, 2'd1, '1);
		send_request(REQ_BAD_LO + 3'd1, 2'd2, '1);
		send_request(REQ_BAD_HI, 2'd3, '1);
		send_request(REQ_POP_FRONT, 2'd3, '0);
		send_request(REQ_POP_REAR, 2'd3, '0);
		send_request(REQ_DUMP, 2'd3, '0);
		send_request(REQ_POP_REAR, 2'd3, '0);
		// single element removed from the front
		send_request(REQ_PUSH_REAR, 2'd1, 32'sh00000001);
		send_request(REQ_POP_FRONT, 2'd1, '0);

		run_random(RANDOM_ITEMS);

		req_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
